>>> src/cs3_pkg.sv
// Shared widths and pipeline depths of the 3x3 Cramer solver.
package cs3_pkg;
  localparam int unsigned InW    = 16;
  localparam int unsigned ProdW  = 2 * InW;
  localparam int unsigned CofW   = ProdW + 1;
  localparam int unsigned TermW  = InW + CofW;
  localparam int unsigned DetW   = TermW + 1;
  localparam int unsigned MagW   = DetW - 1;
  localparam int unsigned FracW  = 16;
  localparam int unsigned QuoW   = 33;
  localparam int unsigned RemW   = MagW + 1;
  localparam int unsigned ExtW   = MagW + FracW;
  localparam int unsigned OutW   = 32;
  localparam int unsigned DetLat = 4;
  localparam int unsigned DivLat = QuoW + 2;
  localparam int unsigned Lat    = DetLat + DivLat;
  localparam int unsigned SInW   = 12 * InW;
  localparam int unsigned MOutW  = 3 * OutW;
  localparam int unsigned MUserW = 2;
endpackage

>>> src/cs3_det.sv
// Four-stage pipelined 3x3 determinant by first-row cofactor expansion.
module cs3_det (
  input  logic                              clk_i,
  input  logic                              ce_i,
  input  logic signed [cs3_pkg::InW-1:0]    m_i [9],
  output logic signed [cs3_pkg::DetW-1:0]   det_o
);
  logic signed [cs3_pkg::ProdW-1:0] p_q [6];
  logic signed [cs3_pkg::InW-1:0]   r1_q [3];
  logic signed [cs3_pkg::InW-1:0]   r2_q [3];
  logic signed [cs3_pkg::CofW-1:0]  c_q [3];
  logic signed [cs3_pkg::TermW-1:0] t_q [3];
  logic signed [cs3_pkg::DetW-1:0]  det_q;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      p_q[0] <= m_i[4] * m_i[8];
      p_q[1] <= m_i[5] * m_i[7];
      p_q[2] <= m_i[3] * m_i[8];
      p_q[3] <= m_i[5] * m_i[6];
      p_q[4] <= m_i[3] * m_i[7];
      p_q[5] <= m_i[4] * m_i[6];
      r1_q[0] <= m_i[0];
      r1_q[1] <= m_i[1];
      r1_q[2] <= m_i[2];
      c_q[0] <= cs3_pkg::CofW'(p_q[0]) - cs3_pkg::CofW'(p_q[1]);
      c_q[1] <= cs3_pkg::CofW'(p_q[2]) - cs3_pkg::CofW'(p_q[3]);
      c_q[2] <= cs3_pkg::CofW'(p_q[4]) - cs3_pkg::CofW'(p_q[5]);
      r2_q   <= r1_q;
      t_q[0] <= cs3_pkg::TermW'(r2_q[0] * c_q[0]);
      t_q[1] <= cs3_pkg::TermW'(r2_q[1] * c_q[1]);
      t_q[2] <= cs3_pkg::TermW'(r2_q[2] * c_q[2]);
      det_q  <= cs3_pkg::DetW'(t_q[0]) - cs3_pkg::DetW'(t_q[1]) + cs3_pkg::DetW'(t_q[2]);
    end
  end

  assign det_o = det_q;
endmodule

>>> src/cs3_div.sv
// Pipelined restoring divider giving a saturated signed Q16.16 quotient.
module cs3_div (
  input  logic                               clk_i,
  input  logic                               ce_i,
  input  logic signed [cs3_pkg::DetW-1:0]    num_i,
  input  logic signed [cs3_pkg::DetW-1:0]    den_i,
  output logic        [cs3_pkg::OutW-1:0]    quo_o,
  output logic                               sat_o
);
  localparam int unsigned QW = cs3_pkg::QuoW;

  logic [cs3_pkg::RemW-1:0] r_q   [QW+1];
  logic [QW-1:0]            bit_q [QW+1];
  logic [QW-1:0]            qt_q  [QW+1];
  logic [cs3_pkg::MagW-1:0] d_q   [QW+1];
  logic                     neg_q [QW+1];
  logic                     ovf_q [QW+1];

  logic [cs3_pkg::DetW-1:0] num_abs, den_abs;
  logic [cs3_pkg::ExtW-1:0] n_ext;
  logic [cs3_pkg::MagW-1:0] d_mag;

  always_comb begin
    num_abs = num_i[cs3_pkg::DetW-1] ? -num_i : num_i;
    den_abs = den_i[cs3_pkg::DetW-1] ? -den_i : den_i;
    d_mag   = den_abs[cs3_pkg::MagW-1:0];
    n_ext   = {num_abs[cs3_pkg::MagW-1:0], {cs3_pkg::FracW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      neg_q[0] <= num_i[cs3_pkg::DetW-1] ^ den_i[cs3_pkg::DetW-1];
      d_q[0]   <= d_mag;
      ovf_q[0] <= cs3_pkg::MagW'(n_ext[cs3_pkg::ExtW-1:QW]) >= d_mag;
      r_q[0]   <= cs3_pkg::RemW'(n_ext[cs3_pkg::ExtW-1:QW]);
      bit_q[0] <= n_ext[QW-1:0];
      qt_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [cs3_pkg::RemW-1:0] t;
    logic                     ge;
    always_comb begin
      t  = {r_q[k][cs3_pkg::RemW-2:0], bit_q[k][QW-1]};
      ge = t >= {1'b0, d_q[k]};
    end
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        r_q[k+1]   <= ge ? t - {1'b0, d_q[k]} : t;
        qt_q[k+1]  <= {qt_q[k][QW-2:0], ge};
        bit_q[k+1] <= {bit_q[k][QW-2:0], 1'b0};
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  logic [QW-1:0] limit, mag, res;
  logic          sat;
  logic [cs3_pkg::OutW-1:0] quo_q;
  logic                     sat_q;

  always_comb begin
    limit = neg_q[QW] ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
    sat   = ovf_q[QW] || (qt_q[QW] > limit);
    mag   = sat ? limit : qt_q[QW];
    res   = neg_q[QW] ? -mag : mag;
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      quo_q <= res[cs3_pkg::OutW-1:0];
      sat_q <= sat;
    end
  end

  assign quo_o = quo_q;
  assign sat_o = sat_q;
endmodule

>>> src/cramer_solve_3x3_unit.sv
// Top level: pipelined 3x3 linear solver by Cramer's rule.
//   channel  | dir | content
//   s_axis   | in  | tdata a11..a33, rhs_x..rhs_z, 16 bits each
//   m_axis   | out | tdata sol_x..sol_z, tuser singular, saturated
// One request per cycle while the output is not stalled; 4 determinant stages, 35 divider stages.
// The divider's one quotient bit per stage sets the depth.
// Reset clears the valid bits only.
// The whole pipeline holds while a result waits and the output is not taken.
module cramer_solve_3x3_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [cs3_pkg::SInW-1:0]     s_axis_tdata,  // a11,a12,a13,a21,a22,a23,a31,a32,a33,rhs_x,rhs_y,rhs_z
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cs3_pkg::MOutW-1:0]    m_axis_tdata,  // sol_x, sol_y, sol_z
  output logic [cs3_pkg::MUserW-1:0]   m_axis_tuser   // singular, saturated
);
  localparam int unsigned W = cs3_pkg::InW;

  logic                             ce;
  logic [cs3_pkg::Lat-1:0]          vld_q;
  logic [cs3_pkg::DivLat-1:0]       sing_q;
  logic signed [W-1:0]              a [9];
  logic signed [W-1:0]              b [3];
  logic signed [W-1:0]              w [3][9];
  logic signed [cs3_pkg::DetW-1:0]  det_d;
  logic signed [cs3_pkg::DetW-1:0]  num [3];
  logic [cs3_pkg::OutW-1:0]         quo [3];
  logic [2:0]                       sat;

  assign ce            = !vld_q[cs3_pkg::Lat-1] || m_axis_tready;
  assign s_axis_tready = ce;

  always_comb begin
    for (int i = 0; i < 9; i++) a[i] = s_axis_tdata[i*W +: W];
    for (int i = 0; i < 3; i++) b[i] = s_axis_tdata[(9+i)*W +: W];
    for (int k = 0; k < 3; k++) begin
      w[k] = a;
      for (int i = 0; i < 3; i++) w[k][i*3+k] = b[i];
    end
  end

  cs3_det u_det_sys (.clk_i, .ce_i(ce), .m_i(a), .det_o(det_d));

  for (genvar k = 0; k < 3; k++) begin : g_col
    cs3_det u_det (.clk_i, .ce_i(ce), .m_i(w[k]), .det_o(num[k]));
    cs3_div u_div (
      .clk_i, .ce_i(ce), .num_i(num[k]), .den_i(det_d), .quo_o(quo[k]), .sat_o(sat[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[cs3_pkg::Lat-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sing_q <= {sing_q[cs3_pkg::DivLat-2:0], det_d == '0};
    end
  end

  logic sing_out;
  assign sing_out      = sing_q[cs3_pkg::DivLat-1];
  assign m_axis_tvalid = vld_q[cs3_pkg::Lat-1];
  assign m_axis_tdata  = sing_out ? '0 : {quo[2], quo[1], quo[0]};
  assign m_axis_tuser  = {!sing_out && (|sat), sing_out};

  a_sing_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("saturated with singular");
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("nonzero singular result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken during stall");
endmodule
